// File: design/trle_pkg.sv
// Shared types and constants of the TGA run-length packet encoder.
package trle_pkg;

  localparam int PIXEL_W = 32;
  localparam int BPP_W = 3;
  localparam int HDR_W = 8;
  localparam int COUNT_W = 2;
  localparam int MAX_PACKET_DEF = 128;
  localparam logic [BPP_W-1:0] BPP_RESET = 3'd4;
  localparam logic [HDR_W-1:0] RUN_BIAS = 8'd127;

  // State of the packet that is being built
  typedef enum logic [1:0] {
    MODE_EMPTY,
    MODE_RAW,
    MODE_RUN
  } mode_t;

  // Kind of one packet that a step has to send
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_RAW,
    KIND_RUN
  } kind_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_RAW_RD,
    ST_RAW_FIRST,
    ST_RAW_SECOND,
    ST_PUSH
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic step;        // take the input word and plan its packets
    logic sel_b;       // move on to the second planned packet
    logic rd_first;    // read raw buffer at the current position
    logic cap_first;   // capture first pixel, read the next one if paired
    logic cap_second;  // capture second pixel
    logic push;        // load the output register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    kind_t cur_kind;   // kind of the packet now being sent
    logic  sel;        // second planned packet is selected
    logic  pair;       // current raw word carries two pixels
    logic  last_item;  // current word closes its packet
    logic  final_item; // current word is the last one of the step
    logic  plan_any;   // the input word on the port would emit something
  } status_t;

endpackage

// File: design/tga_rle_packet_encoder.sv
// TGA run-length packet encoder, top level.
// One pixel word enters per handshake; pixels are compared on their low
// bytes_per_pixel bytes and grouped greedily into run packets (header
// count+127, pixel sent once) and raw packets (header count-1, pixels sent
// two to an output word). A pixel that closes packets holds the input for the
// whole send: the controller takes the word, dispatches each planned packet,
// then pushes a run packet at once and sends each raw word of two pixels by a
// read, a capture of the first pixel, a capture of the second and a push; a
// lone last pixel skips the second capture (the pixels of a raw word come one
// per cycle through the single read port of the raw buffer). A push waits
// while the output word is not taken. The last output word stays in its
// register while the next pixel is taken. The raw buffer needs no clearing
// after reset.
module tga_rle_packet_encoder #(
  parameter int MAX_PACKET = trle_pkg::MAX_PACKET_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [trle_pkg::BPP_W-1:0]    cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [trle_pkg::PIXEL_W-1:0]  pixel_value,
  input  logic                          end_of_image,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          header_present,
  output logic [trle_pkg::HDR_W-1:0]    header_byte,
  output logic [trle_pkg::COUNT_W-1:0]  pixel_count,
  output logic [trle_pkg::PIXEL_W-1:0]  first_pixel,
  output logic [trle_pkg::PIXEL_W-1:0]  second_pixel,
  output logic                          last_of_step,
  output logic                          image_done
);
  import trle_pkg::*;

  cmd_t    cmd;
  status_t st;

  // Sequencer
  trle_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  // Packet state, raw buffer and output word
  trle_datapath #(
    .MAX_PACKET (MAX_PACKET)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .pixel_value    (pixel_value),
    .end_of_image   (end_of_image),
    .cmd            (cmd),
    .st             (st),
    .header_present (header_present),
    .header_byte    (header_byte),
    .pixel_count    (pixel_count),
    .first_pixel    (first_pixel),
    .second_pixel   (second_pixel),
    .last_of_step   (last_of_step),
    .image_done     (image_done)
  );

endmodule

// File: design/trle_ram.sv
// Generic single-write, single-read RAM with registered read data.
module trle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/trle_ctrl.sv
// Controller of the TGA run-length packet encoder: sequences steps and packet output.
module trle_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  trle_pkg::status_t st,
  output trle_pkg::cmd_t    cmd
);
  import trle_pkg::*;

  state_t state, state_next;
  logic   out_valid_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  // State and output-valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Output word is held until taken
  always_comb begin
    if (cmd.push) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && st.plan_any) begin
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (st.cur_kind)
          KIND_RUN: state_next = ST_PUSH;
          KIND_RAW: state_next = ST_RAW_RD;
          default: begin
            if (st.sel) begin
              state_next = ST_IDLE;
            end
          end
        endcase
      end
      ST_RAW_RD:     state_next = ST_RAW_FIRST;
      ST_RAW_FIRST:  state_next = st.pair ? ST_RAW_SECOND : ST_PUSH;
      ST_RAW_SECOND: state_next = ST_PUSH;
      ST_PUSH: begin
        if (out_free) begin
          if (st.final_item) begin
            state_next = ST_IDLE;
          end else if (st.last_item) begin
            state_next = ST_DISPATCH;
          end else begin
            state_next = ST_RAW_RD;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE:       cmd.step = in_valid;
      ST_DISPATCH:   cmd.sel_b = (st.cur_kind == KIND_NONE) && !st.sel;
      ST_RAW_RD:     cmd.rd_first = 1'b1;
      ST_RAW_FIRST:  cmd.cap_first = 1'b1;
      ST_RAW_SECOND: cmd.cap_second = 1'b1;
      ST_PUSH: begin
        if (out_free) begin
          cmd.push  = 1'b1;
          cmd.sel_b = st.last_item && !st.final_item;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

// File: design/trle_datapath.sv
// Datapath of the TGA run-length packet encoder: packet state, raw buffer, output word.
module trle_datapath #(
  parameter int MAX_PACKET = trle_pkg::MAX_PACKET_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [trle_pkg::BPP_W-1:0]    cfg_wr_data,
  input  logic [trle_pkg::PIXEL_W-1:0]  pixel_value,
  input  logic                          end_of_image,
  input  trle_pkg::cmd_t                cmd,
  output trle_pkg::status_t             st,
  output logic                          header_present,
  output logic [trle_pkg::HDR_W-1:0]    header_byte,
  output logic [trle_pkg::COUNT_W-1:0]  pixel_count,
  output logic [trle_pkg::PIXEL_W-1:0]  first_pixel,
  output logic [trle_pkg::PIXEL_W-1:0]  second_pixel,
  output logic                          last_of_step,
  output logic                          image_done
);
  import trle_pkg::*;

  localparam int LEN_W = $clog2(MAX_PACKET + 1);
  localparam int ADDR_W = (MAX_PACKET > 1) ? $clog2(MAX_PACKET) : 1;
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PACKET);
  localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);
  localparam logic [LEN_W-1:0] LEN_TWO = LEN_W'(2);
  localparam bit RUN_FULL_AT_TWO = (MAX_PACKET <= 2);

  // Packet state and configuration
  logic [BPP_W-1:0]   bpp;
  mode_t              mode, mode_next;
  logic [LEN_W-1:0]   len, len_next;
  logic [PIXEL_W-1:0] prev;

  // Planned packets of the current step
  kind_t              a_kind, a_kind_next, b_kind, b_kind_next;
  logic [LEN_W-1:0]   a_len, a_len_next, b_len, b_len_next;
  logic [PIXEL_W-1:0] a_pix, a_pix_next, b_pix, b_pix_next;
  logic               eoi;

  // Send progress
  logic               sel;
  logic [LEN_W-1:0]   pos;
  logic [PIXEL_W-1:0] stage_first, stage_second;

  // Raw buffer ports
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [PIXEL_W-1:0] rd_data;

  // Step decode
  logic [PIXEL_W-1:0] mask, x;
  logic               eq, in_raw, in_run;
  logic [LEN_W-1:0]   len_inc;

  // Current packet view
  kind_t              cur_kind;
  logic [LEN_W-1:0]   cur_len, rem;
  logic [PIXEL_W-1:0] cur_pix;
  logic               pair, last_item, final_item;

  // Pixel mask from the configured size; zero acts as one byte, above four as four
  always_comb begin
    case (bpp)
      3'd0, 3'd1: mask = 32'h0000_00ff;
      3'd2:       mask = 32'h0000_ffff;
      3'd3:       mask = 32'h00ff_ffff;
      default:    mask = 32'hffff_ffff;
    endcase
  end

  assign x       = pixel_value & mask;
  assign eq      = (x == prev);
  assign in_raw  = (mode == MODE_RAW) && (len >= LEN_ONE) && (len < LEN_MAX);
  assign in_run  = (mode == MODE_RUN) && (len >= LEN_ONE) && (len < LEN_MAX);
  assign len_inc = len + LEN_ONE;

  // Packet decision for the word on the input port
  always_comb begin
    a_kind_next = KIND_NONE;
    a_len_next  = len;
    a_pix_next  = x;
    b_kind_next = KIND_NONE;
    b_len_next  = LEN_ONE;
    b_pix_next  = x;
    mode_next   = MODE_RAW;
    len_next    = LEN_ONE;
    wr_en       = 1'b1;
    wr_addr     = '0;
    if (in_raw && eq) begin
      // repeat closes the raw part; the predecessor opens a run
      wr_en     = 1'b0;
      mode_next = MODE_RUN;
      len_next  = LEN_TWO;
      if (len >= LEN_TWO) begin
        a_kind_next = KIND_RAW;
        a_len_next  = len - LEN_ONE;
      end
      if (RUN_FULL_AT_TWO || end_of_image) begin
        b_kind_next = KIND_RUN;
        b_len_next  = LEN_TWO;
        mode_next   = MODE_EMPTY;
        len_next    = '0;
      end
    end else if (in_raw) begin
      wr_addr   = len[ADDR_W-1:0];
      len_next  = len_inc;
      if ((len_inc >= LEN_MAX) || end_of_image) begin
        a_kind_next = KIND_RAW;
        a_len_next  = len_inc;
        mode_next   = MODE_EMPTY;
        len_next    = '0;
      end
    end else if (in_run && eq) begin
      wr_en     = 1'b0;
      mode_next = MODE_RUN;
      len_next  = len_inc;
      if ((len_inc >= LEN_MAX) || end_of_image) begin
        a_kind_next = KIND_RUN;
        a_len_next  = len_inc;
        mode_next   = MODE_EMPTY;
        len_next    = '0;
      end
    end else if (in_run) begin
      // run ends on a new pixel, which opens a raw packet
      a_kind_next = KIND_RUN;
      a_len_next  = len;
      a_pix_next  = prev;
      if (end_of_image) begin
        b_kind_next = KIND_RAW;
        mode_next   = MODE_EMPTY;
        len_next    = '0;
      end
    end else begin
      if (end_of_image) begin
        a_kind_next = KIND_RAW;
        a_len_next  = LEN_ONE;
        mode_next   = MODE_EMPTY;
        len_next    = '0;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bpp    <= BPP_RESET;
      mode   <= MODE_EMPTY;
      len    <= '0;
      prev   <= '0;
      a_kind <= KIND_NONE;
      b_kind <= KIND_NONE;
      sel    <= 1'b0;
      pos    <= '0;
    end else begin
      if (cfg_wr_en) begin
        bpp <= cfg_wr_data;
      end
      if (cmd.step) begin
        mode   <= mode_next;
        len    <= len_next;
        prev   <= x;
        a_kind <= a_kind_next;
        b_kind <= b_kind_next;
        sel    <= 1'b0;
        pos    <= '0;
      end else if (cmd.sel_b) begin
        sel <= 1'b1;
        pos <= '0;
      end else if (cmd.push) begin
        pos <= pos + LEN_TWO;
      end
    end
  end

  // Plan payload
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      a_len <= a_len_next;
      a_pix <= a_pix_next;
      b_len <= b_len_next;
      b_pix <= b_pix_next;
      eoi   <= end_of_image;
    end
  end

  // Raw buffer
  assign rd_en   = cmd.rd_first || (cmd.cap_first && pair);
  assign rd_addr = cmd.rd_first ? pos[ADDR_W-1:0] : ADDR_W'(pos + LEN_ONE);

  trle_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (MAX_PACKET)
  ) u_raw_buffer (
    .clk     (clk),
    .wr_en   (cmd.step && wr_en),
    .wr_addr (wr_addr),
    .wr_data (x),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Pixel staging for raw words
  always_ff @(posedge clk) begin
    if (cmd.cap_first) begin
      stage_first <= rd_data;
    end
    if (cmd.cap_second) begin
      stage_second <= rd_data;
    end
  end

  // Current packet and word position
  assign cur_kind   = sel ? b_kind : a_kind;
  assign cur_len    = sel ? b_len : a_len;
  assign cur_pix    = sel ? b_pix : a_pix;
  assign rem        = cur_len - pos;
  assign pair       = (cur_kind == KIND_RAW) && (rem >= LEN_TWO);
  assign last_item  = (cur_kind != KIND_RAW) || (rem <= LEN_TWO);
  assign final_item = last_item && (sel || (b_kind == KIND_NONE));

  assign st.cur_kind   = cur_kind;
  assign st.sel        = sel;
  assign st.pair       = pair;
  assign st.last_item  = last_item;
  assign st.final_item = final_item;
  assign st.plan_any   = (a_kind_next != KIND_NONE) || (b_kind_next != KIND_NONE);

  // Output word register
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      last_of_step <= final_item;
      image_done   <= final_item && eoi;
      if (cur_kind == KIND_RUN) begin
        header_present <= 1'b1;
        header_byte    <= HDR_W'(cur_len) + RUN_BIAS;
        pixel_count    <= COUNT_W'(1);
        first_pixel    <= cur_pix;
        second_pixel   <= '0;
      end else begin
        header_present <= (pos == '0);
        header_byte    <= (pos == '0) ? (HDR_W'(cur_len) - HDR_W'(1)) : '0;
        pixel_count    <= pair ? COUNT_W'(2) : COUNT_W'(1);
        first_pixel    <= stage_first;
        second_pixel   <= pair ? stage_second : '0;
      end
    end
  end

endmodule
